@@ src/assert_macros.svh @@
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// Expression that holds on every clock edge outside reset.
`define ASSERT_HOLD(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

@@ src/tidtar_pkg.sv @@
// Types, widths and codes for the tile id to atlas rectangle block.
package tidtar_pkg;

   localparam int NUM_SETS_DEF = 8;
   localparam int ID_BITS_DEF  = 16;

   localparam int SLOT_W     = 3;
   localparam int ACROSS_W   = 9;
   localparam int SIZE_W     = 9;
   localparam int MAP_W      = 10;
   localparam int DEST_W     = 18;
   localparam int SRC_W      = 24;
   localparam int EDGE_W     = 25;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [SIZE_W-1:0] TILE_SIZE_RST = 9'd32;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_MATCH  = 2'd1,
      STATUS_NO_ACROSS = 2'd2
   } status_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_MAP  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_WIDTH  = 2'd0,
      CSR_TILE_HEIGHT = 2'd1
   } csr_index_type;

endpackage

@@ src/tile_id_to_atlas_rect.sv @@
// Top level: tileset table lookup and pipelined atlas rectangle generation.
//
//   channel  ports                      handshake
//   -------  -------------------------  --------------------------------------
//   input    start, busy, req_*         item taken at edge with start & !busy
//   result   rsp_valid, rsp_*           one-cycle strobe, no back-pressure
//   config   csr_wr_en, csr_index/wdata write at edge with csr_wr_en
//
// One item per cycle while busy is low. A map item passes the lookup register,
// the divider entry, the restoring divider (one quotient bit per stage), the
// source product register and the result register. Load items give no result.
// busy is reset delayed by one register. The receiver cannot stall.
`include "assert_macros.svh"

module tile_id_to_atlas_rect import tidtar_pkg::*; #(
   parameter int NUM_SETS = NUM_SETS_DEF,
   parameter int ID_BITS  = ID_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [ID_BITS-1:0]    req_first_id,
   input  logic [ID_BITS-1:0]    req_end_id,
   input  logic [ACROSS_W-1:0]   req_tiles_across,
   input  logic [MAP_W-1:0]      req_map_row,
   input  logic [MAP_W-1:0]      req_map_column,
   input  logic [ID_BITS-1:0]    req_tile_id,
   output logic                  rsp_valid,
   output logic [DEST_W-1:0]     rsp_dest_x,
   output logic [DEST_W-1:0]     rsp_dest_y,
   output logic [SRC_W-1:0]      rsp_src_left,
   output logic [SRC_W-1:0]      rsp_src_top,
   output logic [EDGE_W-1:0]     rsp_src_right,
   output logic [EDGE_W-1:0]     rsp_src_bottom,
   output logic [SLOT_W-1:0]     rsp_set_slot,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int LAT     = ID_BITS + 4;
   localparam int REM_W   = ACROSS_W;
   localparam int DPROD_W = MAP_W + SIZE_W;
   localparam int LPROD_W = REM_W + SIZE_W;
   localparam int TOP_W   = (ID_BITS + SIZE_W > SRC_W) ? ID_BITS + SIZE_W : SRC_W;

   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic [ID_BITS-1:0]  first;
      logic [ACROSS_W-1:0] across;
      logic [ID_BITS-1:0]  id;
      logic [MAP_W-1:0]    row;
      logic [MAP_W-1:0]    col;
   } look_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [ACROSS_W-1:0] across;
      logic [REM_W-1:0]    rem;
      logic [ID_BITS-1:0]  dq;
      logic [DEST_W-1:0]   dest_x;
      logic [DEST_W-1:0]   dest_y;
   } div_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [SRC_W-1:0]    left;
      logic [SRC_W-1:0]    top;
      logic [DEST_W-1:0]   dest_x;
      logic [DEST_W-1:0]   dest_y;
   } prod_type;

   // configuration
   logic [SIZE_W-1:0] tile_width_ff;
   logic [SIZE_W-1:0] tile_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff  <= TILE_SIZE_RST;
         tile_height_ff <= TILE_SIZE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TILE_WIDTH:  tile_width_ff  <= csr_wdata;
            CSR_TILE_HEIGHT: tile_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy = busy_ff;

   logic accept;
   logic load_we;
   logic [IDX_W-1:0] widx;

   assign accept  = start && !busy_ff;
   assign load_we = accept && (req_cmd == CMD_LOAD)
                    && ({29'd0, req_slot} < 32'(NUM_SETS));
   assign widx    = IDX_W'(req_slot);

   // tileset table
   logic [NUM_SETS-1:0] set_valid_ff;
   logic [ID_BITS-1:0]  set_first_ff  [NUM_SETS];
   logic [ID_BITS-1:0]  set_end_ff    [NUM_SETS];
   logic [ACROSS_W-1:0] set_across_ff [NUM_SETS];

   always_ff @(posedge clock) begin
      if (reset) begin
         set_valid_ff <= '0;
      end else if (load_we) begin
         set_valid_ff[widx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         set_first_ff[widx]  <= req_first_id;
         set_end_ff[widx]    <= req_end_id;
         set_across_ff[widx] <= req_tiles_across;
      end
   end

   // lookup: highest matching slot wins
   look_type look_in;
   look_type look_ff;
   logic     look_vld_ff;

   always_comb begin
      look_in        = '0;
      look_in.id     = req_tile_id;
      look_in.row    = req_map_row;
      look_in.col    = req_map_column;
      for (int i = 0; i < NUM_SETS; i++) begin
         if (set_valid_ff[i] && (req_tile_id >= set_first_ff[i])
             && (req_tile_id < set_end_ff[i])) begin
            look_in.hit    = 1'b1;
            look_in.slot   = SLOT_W'(i);
            look_in.first  = set_first_ff[i];
            look_in.across = set_across_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         look_vld_ff <= 1'b0;
      end else begin
         look_vld_ff <= accept && (req_cmd == CMD_MAP);
      end
   end

   always_ff @(posedge clock) begin
      look_ff <= look_in;
   end

   // offset, status and destination products; divider entry
   div_type            div_in  [ID_BITS+1];
   div_type            div_ff  [ID_BITS+1];
   logic [ID_BITS:0]   div_vld_ff;
   logic [DPROD_W-1:0] dx_full;
   logic [DPROD_W-1:0] dy_full;

   always_comb begin
      dx_full = DPROD_W'(look_ff.col) * DPROD_W'(tile_width_ff);
      dy_full = DPROD_W'(look_ff.row) * DPROD_W'(tile_height_ff);
      div_in[0]        = '0;
      div_in[0].across = look_ff.across;
      div_in[0].dq     = look_ff.id - look_ff.first;
      div_in[0].dest_x = dx_full[DEST_W-1:0];
      div_in[0].dest_y = dy_full[DEST_W-1:0];
      if (!look_ff.hit) begin
         div_in[0].status = STATUS_NO_MATCH;
      end else begin
         div_in[0].slot = look_ff.slot;
         if (look_ff.across == '0) begin
            div_in[0].status = STATUS_NO_ACROSS;
         end else begin
            div_in[0].status = STATUS_OK;
         end
      end
   end

   for (genvar k = 1; k <= ID_BITS; k++) begin : g_div
      logic [REM_W:0] trial;
      logic [REM_W:0] diff;
      logic           ge;

      always_comb begin
         trial     = {div_ff[k-1].rem, div_ff[k-1].dq[ID_BITS-1]};
         diff      = trial - {1'b0, div_ff[k-1].across};
         ge        = trial >= {1'b0, div_ff[k-1].across};
         div_in[k] = div_ff[k-1];
         div_in[k].rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
         div_in[k].dq  = {div_ff[k-1].dq[ID_BITS-2:0], ge};
      end
   end

   for (genvar k = 0; k <= ID_BITS; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         div_ff[k] <= div_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
      end else begin
         div_vld_ff <= {div_vld_ff[ID_BITS-1:0], look_vld_ff};
      end
   end

   // source products
   prod_type           prod_in;
   prod_type           prod_ff;
   logic               prod_vld_ff;
   logic [LPROD_W-1:0] left_full;
   logic [TOP_W-1:0]   top_full;

   always_comb begin
      left_full      = LPROD_W'(div_ff[ID_BITS].rem) * LPROD_W'(tile_width_ff);
      top_full       = TOP_W'(div_ff[ID_BITS].dq) * TOP_W'(tile_height_ff);
      prod_in.status = div_ff[ID_BITS].status;
      prod_in.slot   = div_ff[ID_BITS].slot;
      prod_in.left   = SRC_W'(left_full);
      prod_in.top    = top_full[SRC_W-1:0];
      prod_in.dest_x = div_ff[ID_BITS].dest_x;
      prod_in.dest_y = div_ff[ID_BITS].dest_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= div_vld_ff[ID_BITS];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // result register
   logic                rsp_valid_ff;
   logic [DEST_W-1:0]   dest_x_ff;
   logic [DEST_W-1:0]   dest_y_ff;
   logic [SRC_W-1:0]    src_left_ff;
   logic [SRC_W-1:0]    src_top_ff;
   logic [EDGE_W-1:0]   src_right_ff;
   logic [EDGE_W-1:0]   src_bottom_ff;
   logic [SLOT_W-1:0]   set_slot_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                ok;

   assign ok = (prod_ff.status == STATUS_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      dest_x_ff     <= prod_ff.dest_x;
      dest_y_ff     <= prod_ff.dest_y;
      set_slot_ff   <= prod_ff.slot;
      status_ff     <= prod_ff.status;
      src_left_ff   <= ok ? prod_ff.left : '0;
      src_top_ff    <= ok ? prod_ff.top : '0;
      src_right_ff  <= ok ? EDGE_W'(prod_ff.left) + EDGE_W'(tile_width_ff) : '0;
      src_bottom_ff <= ok ? EDGE_W'(prod_ff.top) + EDGE_W'(tile_height_ff) : '0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dest_x     = dest_x_ff;
   assign rsp_dest_y     = dest_y_ff;
   assign rsp_src_left   = src_left_ff;
   assign rsp_src_top    = src_top_ff;
   assign rsp_src_right  = src_right_ff;
   assign rsp_src_bottom = src_bottom_ff;
   assign rsp_set_slot   = set_slot_ff;
   assign rsp_status     = status_ff;

   `ASSERT_IMPL(a_map_latency, clock, reset, start && !busy && req_cmd == CMD_MAP, ##LAT rsp_valid, "map item lost")
   `ASSERT_IMPL(a_load_silent, clock, reset, start && !busy && req_cmd == CMD_LOAD, ##LAT !rsp_valid, "load item gave a result")
   `ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, (rsp_src_left == '0 && rsp_src_top == '0 && rsp_src_right == '0 && rsp_src_bottom == '0), "error result carries a rectangle")
   `ASSERT_HOLD(a_nomatch_slot, clock, reset, !(rsp_valid && rsp_status == STATUS_NO_MATCH) || rsp_set_slot == '0, "unmatched item carries a slot")

endmodule

@@ tb/tb.sv @@
// Self-checking bench for tile_id_to_atlas_rect: directed rows, then random items per tile size.
module tb import tidtar_pkg::*; ();

   localparam int LATENCY         = ID_BITS_DEF + 4;
   localparam int SETTLE_CYCLES   = LATENCY + 4;
   localparam int NUM_PHASES      = 7;
   localparam int ITEMS_PER_PHASE = 155;
   localparam int MAX_REPORTS     = 100;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      cmd_type                 cmd;
      logic [SLOT_W-1:0]       slot;
      logic [ID_BITS_DEF-1:0]  first_id;
      logic [ID_BITS_DEF-1:0]  end_id;
      logic [ACROSS_W-1:0]     tiles_across;
      logic [MAP_W-1:0]        map_row;
      logic [MAP_W-1:0]        map_column;
      logic [ID_BITS_DEF-1:0]  tile_id;
   } tile_req_type;

   typedef struct packed {
      logic [DEST_W-1:0] dest_x;
      logic [DEST_W-1:0] dest_y;
      logic [SRC_W-1:0]  src_left;
      logic [SRC_W-1:0]  src_top;
      logic [EDGE_W-1:0] src_right;
      logic [EDGE_W-1:0] src_bottom;
      logic [SLOT_W-1:0] set_slot;
      status_type        status;
   } tile_rect_type;

   typedef struct packed {
      tile_req_type  req;
      logic          known;
      tile_rect_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic                  req_cmd = 1'b0;
   logic [SLOT_W-1:0]     req_slot = '0;
   logic [ID_BITS_DEF-1:0] req_first_id = '0;
   logic [ID_BITS_DEF-1:0] req_end_id = '0;
   logic [ACROSS_W-1:0]   req_tiles_across = '0;
   logic [MAP_W-1:0]      req_map_row = '0;
   logic [MAP_W-1:0]      req_map_column = '0;
   logic [ID_BITS_DEF-1:0] req_tile_id = '0;
   logic                  rsp_valid;
   logic [DEST_W-1:0]     rsp_dest_x;
   logic [DEST_W-1:0]     rsp_dest_y;
   logic [SRC_W-1:0]      rsp_src_left;
   logic [SRC_W-1:0]      rsp_src_top;
   logic [EDGE_W-1:0]     rsp_src_right;
   logic [EDGE_W-1:0]     rsp_src_bottom;
   logic [SLOT_W-1:0]     rsp_set_slot;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted block state
   bit          tileset_valid[NUM_SETS_DEF];
   int unsigned tileset_first[NUM_SETS_DEF];
   int unsigned tileset_end_id[NUM_SETS_DEF];
   int unsigned tileset_across[NUM_SETS_DEF];
   int unsigned px_width = TILE_SIZE_RST;
   int unsigned px_height = TILE_SIZE_RST;

   tile_rect_type pending_rects[$];
   tile_rect_type rect_want;
   stim_row_type  directed_rows[$];
   int            mismatch_count = 0;
   int            burst_left = 0;
   bit            idle_on = 1'b0;

   tile_id_to_atlas_rect u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_slot         (req_slot),
      .req_first_id     (req_first_id),
      .req_end_id       (req_end_id),
      .req_tiles_across (req_tiles_across),
      .req_map_row      (req_map_row),
      .req_map_column   (req_map_column),
      .req_tile_id      (req_tile_id),
      .rsp_valid        (rsp_valid),
      .rsp_dest_x       (rsp_dest_x),
      .rsp_dest_y       (rsp_dest_y),
      .rsp_src_left     (rsp_src_left),
      .rsp_src_top      (rsp_src_top),
      .rsp_src_right    (rsp_src_right),
      .rsp_src_bottom   (rsp_src_bottom),
      .rsp_set_slot     (rsp_set_slot),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic tile_rect_type resolve_tile(tile_req_type r);
      tile_rect_type o;
      int            hit;
      int unsigned   id, offs, left, top;
      o = '0;
      hit = -1;
      id = r.tile_id;
      o.dest_x = DEST_W'(int'(r.map_column) * px_width);
      o.dest_y = DEST_W'(int'(r.map_row) * px_height);
      for (int i = 0; i < NUM_SETS_DEF; i++) begin
         if (tileset_valid[i] && id >= tileset_first[i] && id < tileset_end_id[i]) begin
            hit = i;
         end
      end
      if (hit < 0) begin
         o.status = STATUS_NO_MATCH;
      end else begin
         o.set_slot = SLOT_W'(hit);
         if (tileset_across[hit] == 0) begin
            o.status = STATUS_NO_ACROSS;
         end else begin
            offs = id - tileset_first[hit];
            left = ((offs % tileset_across[hit]) * px_width) & 32'hFF_FFFF;
            top = ((offs / tileset_across[hit]) * px_height) & 32'hFF_FFFF;
            o.src_left = SRC_W'(left);
            o.src_top = SRC_W'(top);
            o.src_right = EDGE_W'(left + px_width);
            o.src_bottom = EDGE_W'(top + px_height);
            o.status = STATUS_OK;
         end
      end
      return o;
   endfunction

   function automatic stim_row_type row_load(int s, int f, int e, int a);
      stim_row_type row;
      row = '0;
      row.req.cmd = CMD_LOAD;
      row.req.slot = SLOT_W'(s);
      row.req.first_id = ID_BITS_DEF'(f);
      row.req.end_id = ID_BITS_DEF'(e);
      row.req.tiles_across = ACROSS_W'(a);
      return row;
   endfunction

   function automatic stim_row_type row_map(int r, int c, int id);
      stim_row_type row;
      row = '0;
      row.req.cmd = CMD_MAP;
      row.req.map_row = MAP_W'(r);
      row.req.map_column = MAP_W'(c);
      row.req.tile_id = ID_BITS_DEF'(id);
      return row;
   endfunction

   function automatic stim_row_type row_map_known(int r, int c, int id, int dx, int dy, int l,
                                                  int t, int rt, int b, int s, status_type st);
      stim_row_type row;
      row = row_map(r, c, id);
      row.known = 1'b1;
      row.want.dest_x = DEST_W'(dx);
      row.want.dest_y = DEST_W'(dy);
      row.want.src_left = SRC_W'(l);
      row.want.src_top = SRC_W'(t);
      row.want.src_right = EDGE_W'(rt);
      row.want.src_bottom = EDGE_W'(b);
      row.want.set_slot = SLOT_W'(s);
      row.want.status = st;
      return row;
   endfunction

   function automatic tile_req_type random_tile_req();
      tile_req_type r;
      int           s;
      int unsigned  f;
      r = '0;
      r.cmd = ($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_MAP;
      r.slot = SLOT_W'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) begin
         r.map_row = MAP_W'($urandom_range(0, 15));
         r.map_column = MAP_W'($urandom_range(0, 15));
      end else begin
         r.map_row = MAP_W'($urandom);
         r.map_column = MAP_W'($urandom);
      end
      if (r.cmd == CMD_LOAD) begin
         case ($urandom_range(0, 3))
            0, 1: begin
               f = $urandom_range(0, 4000);
               r.first_id = ID_BITS_DEF'(f);
               r.end_id = ID_BITS_DEF'(f + $urandom_range(1, 3000));
            end
            2: begin
               r.first_id = ID_BITS_DEF'($urandom);
               r.end_id = ID_BITS_DEF'($urandom);
            end
            default: begin
               f = $urandom_range(0, 65535);
               r.first_id = ID_BITS_DEF'(f);
               r.end_id = ID_BITS_DEF'($urandom_range(0, f));
            end
         endcase
         case ($urandom_range(0, 7))
            0: r.tiles_across = '0;
            1: r.tiles_across = ACROSS_W'($urandom_range(256, 511));
            2: r.tiles_across = ACROSS_W'(1);
            default: r.tiles_across = ACROSS_W'($urandom_range(1, 32));
         endcase
         r.map_row = MAP_W'($urandom);
         r.tile_id = ID_BITS_DEF'($urandom);
      end else begin
         s = $urandom_range(0, NUM_SETS_DEF - 1);
         r.tile_id = ID_BITS_DEF'($urandom);
         if (tileset_valid[s] && tileset_first[s] < tileset_end_id[s]) begin
            case ($urandom_range(0, 7))
               0: r.tile_id = ID_BITS_DEF'(tileset_end_id[s]);
               1: r.tile_id = ID_BITS_DEF'(tileset_first[s]);
               2: ;
               default: r.tile_id = ID_BITS_DEF'($urandom_range(tileset_first[s],
                                                                tileset_end_id[s] - 1));
            endcase
         end
         r.first_id = ID_BITS_DEF'($urandom);
         r.end_id = ID_BITS_DEF'($urandom);
         r.tiles_across = ACROSS_W'($urandom);
      end
      return r;
   endfunction

   task automatic add_row(stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_REPORTS) begin
         $display("rect check: %s", msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic send_tile_req(tile_req_type r, logic known, tile_rect_type want);
      int gap;
      bit taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(4, 40);
         idle_on = $urandom_range(0, 3) != 0;
      end
      burst_left--;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= r.cmd;
      req_slot <= r.slot;
      req_first_id <= r.first_id;
      req_end_id <= r.end_id;
      req_tiles_across <= r.tiles_across;
      req_map_row <= r.map_row;
      req_map_column <= r.map_column;
      req_tile_id <= r.tile_id;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = busy === 1'b0;
         @(posedge clock);
      end
      if (r.cmd == CMD_LOAD) begin
         tileset_valid[r.slot] = 1'b1;
         tileset_first[r.slot] = r.first_id;
         tileset_end_id[r.slot] = r.end_id;
         tileset_across[r.slot] = r.tiles_across;
      end else if (known) begin
         pending_rects.insert(pending_rects.size(), want);
      end else begin
         pending_rects.insert(pending_rects.size(), resolve_tile(r));
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_TILE_WIDTH) begin
         px_width = val;
      end else if (idx == CSR_TILE_HEIGHT) begin
         px_height = val;
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_rects.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_items(int count);
      for (int i = 0; i < count; i++) begin
         send_tile_req(random_tile_req(), 1'b0, '0);
      end
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rects.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            rect_want = pending_rects.pop_front();
            check_field("dest_x", rsp_dest_x, rect_want.dest_x);
            check_field("dest_y", rsp_dest_y, rect_want.dest_y);
            check_field("src_left", rsp_src_left, rect_want.src_left);
            check_field("src_top", rsp_src_top, rect_want.src_top);
            check_field("src_right", rsp_src_right, rect_want.src_right);
            check_field("src_bottom", rsp_src_bottom, rect_want.src_bottom);
            check_field("set_slot", rsp_set_slot, rect_want.set_slot);
            check_field("status", rsp_status, rect_want.status);
         end
      end
   end

   initial begin
      int unsigned w, h;
      // empty table, extremes of position
      add_row(row_map_known(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_NO_MATCH));
      add_row(row_map_known(1023, 1023, 65535, 32736, 32736, 0, 0, 0, 0, 0,
                            STATUS_NO_MATCH));
      // zero across
      add_row(row_load(0, 0, 65535, 0));
      add_row(row_map_known(5, 7, 100, 224, 160, 0, 0, 0, 0, 0, STATUS_NO_ACROSS));
      // higher slot wins; end id is exclusive
      add_row(row_load(1, 0, 16, 4));
      add_row(row_map_known(0, 0, 5, 0, 0, 32, 32, 64, 64, 1, STATUS_OK));
      add_row(row_map_known(0, 0, 15, 0, 0, 96, 96, 128, 128, 1, STATUS_OK));
      add_row(row_map_known(2, 3, 16, 96, 64, 0, 0, 0, 0, 0, STATUS_NO_ACROSS));
      add_row(row_load(7, 65534, 65535, 511));
      add_row(row_map_known(0, 0, 65534, 0, 0, 0, 0, 32, 32, 7, STATUS_OK));
      add_row(row_map_known(1, 1, 65535, 32, 32, 0, 0, 0, 0, 0, STATUS_NO_MATCH));
      // empty range never matches
      add_row(row_load(2, 10, 5, 1));
      add_row(row_map_known(0, 0, 7, 0, 0, 96, 32, 128, 64, 1, STATUS_OK));
      add_row(row_load(6, 1000, 65535, 256));
      add_row(row_map_known(1023, 0, 65000, 0, 32736, 0, 8000, 32, 8032, 6, STATUS_OK));
      add_row(row_load(4, 16'h5555, 16'hAAAA, 9'h155));
      add_row(row_load(6, 16'hAAAA, 16'hFFFF, 9'h0AA));
      add_row(row_map(10'h155, 10'h2AA, 16'h6000));
      add_row(row_map(10'h2AA, 10'h155, 16'hC000));
      add_row(row_load(3, 20, 30, 1));
      add_row(row_map_known(0, 0, 25, 0, 0, 0, 160, 32, 192, 3, STATUS_OK));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_tile_req(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);
      end
      random_items(ITEMS_PER_PHASE);

      for (int p = 1; p < NUM_PHASES; p++) begin
         wait_idle();
         case (p)
            1: begin w = 1; h = 1; end
            2: begin w = 256; h = 256; end
            3: begin w = 511; h = 511; end
            4: begin w = 0; h = 0; end
            5: begin w = $urandom_range(1, 256); h = $urandom_range(1, 256); end
            default: begin w = $urandom_range(0, 511); h = $urandom_range(0, 511); end
         endcase
         write_csr(CSR_TILE_WIDTH, CSR_DATA_W'(w));
         write_csr(CSR_TILE_HEIGHT, CSR_DATA_W'(h));
         // unmapped indexes must leave the sizes alone
         write_csr((p % 2 == 0) ? CSR_SPARE_A : CSR_SPARE_B, CSR_DATA_W'($urandom));
         csr_wr_en <= 1'b0;
         random_items(ITEMS_PER_PHASE);
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("tile_id_to_atlas_rect: match");
      end else begin
         $display("tile_id_to_atlas_rect: mismatch");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tile_id_to_atlas_rect: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/tidtar_pkg.sv
src/tile_id_to_atlas_rect.sv
tb/tb.sv
